### sv/crcps_pkg.sv
// Package for the reflected CRC-32 streaming block: input word type,
// polynomial constants and the byte-wise CRC lookup table.
// No dependencies.
package crcps_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CrcW   = 32;
  localparam int unsigned TableN = 256;

  localparam logic [CrcW-1:0] CrcPoly     = 32'h04C11DB7;
  localparam logic [CrcW-1:0] CrcPolyRefl = {<<{CrcPoly}};

  localparam int unsigned FoldBytes = 2;

  typedef logic [TableN-1:0][CrcW-1:0] crc_table_t;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
    logic [CrcW-1:0]  seed_value;
  } in_word_t;

  function automatic crc_table_t build_crc_table();
    crc_table_t tbl;
    logic [CrcW-1:0] c;
    for (int i = 0; i < TableN; i++) begin
      c = CrcW'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
      end
      tbl[i] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t CrcTable = build_crc_table();

endpackage

### sv/crcps_in_stage.sv
// Input register stage: captures one word per accepted handshake.
// Depends on crcps_pkg for the input word type.
module crcps_in_stage import crcps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_word_i,
  input  logic     advance_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### sv/crcps_core.sv
// CRC state and byte fold: running CRC, saved seed and entry position.
// Depends on crcps_pkg for the table and the input word type.
module crcps_core import crcps_pkg::*; #(
  parameter int unsigned EntryBytes = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  in_word_t        word_i,
  input  logic            palette_mode_i,
  output logic [CrcW-1:0] result_o
);

  localparam int unsigned PosW = (EntryBytes > 1) ? $clog2(EntryBytes) : 1;

  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] seed_q, seed_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic [CrcW-1:0] crc_base;
  logic [PosW-1:0] pos_base;
  logic [DataW-1:0] idx;
  logic            fold;

  always_comb begin
    crc_base = word_i.first_byte ? word_i.seed_value : crc_q;
    seed_d   = word_i.first_byte ? word_i.seed_value : seed_q;
    pos_base = word_i.first_byte ? '0 : pos_q;
    fold     = !palette_mode_i || (int'(pos_base) < int'(FoldBytes));
    idx      = crc_base[DataW-1:0] ^ word_i.data_byte;
    crc_d    = fold ? ((crc_base >> DataW) ^ CrcTable[idx]) : crc_base;
    pos_d    = (pos_base == PosW'(EntryBytes - 1)) ? '0 : pos_base + PosW'(1);
  end

  assign result_o = crc_d ^ seed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      seed_q <= '0;
      pos_q  <= '0;
    end else if (advance_i) begin
      crc_q  <= crc_d;
      seed_q <= seed_d;
      pos_q  <= pos_d;
    end
  end

endmodule

### sv/crc32_reflected_with_palette_stride.sv
// Reflected CRC-32 over a byte stream, optional palette stride.
// The accepted byte is registered in the input stage, then the result word in the output register.
// Throughput: one byte per cycle, unless a last byte waits on a full output register.
// Reset (rst_ni low, async): CRC, seed, entry position, mode cleared to zero.
// Depends on crcps_pkg, crcps_in_stage and crcps_core.
module crc32_reflected_with_palette_stride import crcps_pkg::*; #(
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,  // [7:0] data_byte, [39:8] seed_value
  input  logic            s_axis_tlast,  // last_byte
  input  logic            s_axis_tuser,  // first_byte
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [CrcW-1:0] m_axis_tdata   // [31:0] crc_result
);

  logic            palette_q;
  in_word_t        in_word;
  in_word_t        st_word;
  logic            st_valid;
  logic            advance;
  logic            out_free;
  logic [CrcW-1:0] result;
  logic            m_valid_q, m_valid_d;
  logic [CrcW-1:0] m_data_q;

  assign in_word.data_byte  = s_axis_tdata[DataW-1:0];
  assign in_word.first_byte = s_axis_tuser;
  assign in_word.last_byte  = s_axis_tlast;
  assign in_word.seed_value = s_axis_tdata[DataW +: CrcW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= 1'b0;
    end else if (cfg_we_i) begin
      palette_q <= cfg_wdata_i;
    end
  end

  crcps_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_word_i  (in_word),
    .advance_i  (advance),
    .valid_o    (st_valid),
    .word_o     (st_word)
  );

  crcps_core #(
    .EntryBytes (ENTRY_BYTES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .word_i         (st_word),
    .palette_mode_i (palette_q),
    .result_o       (result)
  );

  assign out_free = !m_valid_q || m_axis_tready;
  assign advance  = st_valid && (!st_word.last_byte || out_free);

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    if (advance && st_word.last_byte) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && st_word.last_byte) begin
      m_data_q <= result;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_rise_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(advance && st_word.last_byte))
    else $error("result word without a last byte");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_valid |-> s_axis_tready)
    else $error("input stalled with empty stage");

  a_hold_on_blocked_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid && st_word.last_byte && m_valid_q && !m_axis_tready)
      |-> (!advance && !s_axis_tready))
    else $error("last byte advanced into a full output register");

  a_no_advance_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_valid |-> !advance)
    else $error("state advanced without a staged byte");
`endif

endmodule

### verif/crc32_stream_checker.sv
`timescale 1ns / 100ps
// Checker for crc32_reflected_with_palette_stride: watches the config port and both
// stream channels, predicts each crc_result word and compares it in order.
// Depends on crcps_pkg.
module crc32_stream_checker import crcps_pkg::*; #(
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            s_tvalid_i,
  input  logic            s_tready_i,
  input  logic [39:0]     s_tdata_i,
  input  logic            s_tlast_i,
  input  logic            s_tuser_i,
  input  logic            m_tvalid_i,
  input  logic            m_tready_i,
  input  logic [CrcW-1:0] m_tdata_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o
);

  localparam logic [CrcW-1:0] ReflPoly = 32'hEDB88320;
  localparam int unsigned     MaxPrints = 40;

  logic [CrcW-1:0] crc_acc;
  logic [CrcW-1:0] seed_hold;
  int unsigned     entry_idx;
  logic            palette_on;
  logic [CrcW-1:0] crc_expected_q[$];
  logic [CrcW-1:0] want_crc;
  in_word_t        word;

  function automatic logic [CrcW-1:0] crc_fold(logic [CrcW-1:0] crc, logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ CrcW'(b);
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ ReflPoly) : (c >> 1);
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches_o < MaxPrints) $display("%0t checker: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc = '0;
      seed_hold = '0;
      entry_idx = 0;
      palette_on = 1'b0;
      crc_expected_q.delete();
      mismatches_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) palette_on = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        word.data_byte  = s_tdata_i[7:0];
        word.seed_value = s_tdata_i[39:8];
        word.first_byte = s_tuser_i;
        word.last_byte  = s_tlast_i;
        if (word.first_byte) begin
          crc_acc = word.seed_value;
          seed_hold = word.seed_value;
          entry_idx = 0;
        end
        if (!palette_on || entry_idx < FoldBytes) crc_acc = crc_fold(crc_acc, word.data_byte);
        entry_idx = (entry_idx + 1 >= ENTRY_BYTES) ? 0 : entry_idx + 1;
        if (word.last_byte) crc_expected_q.push_back(crc_acc ^ seed_hold);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (crc_expected_q.size() == 0) begin
          note_mismatch($sformatf("unexpected crc_result %08h", m_tdata_i));
        end else begin
          want_crc = crc_expected_q.pop_front();
          if (m_tdata_i !== want_crc)
            note_mismatch($sformatf("crc_result got %08h want %08h", m_tdata_i, want_crc));
        end
      end
      pending_o <= crc_expected_q.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Top of the CRC-32 palette stride testbench: clock, reset, config writes, byte
// stimulus and output stalls. Depends on crcps_pkg, the block and crc32_stream_checker.
module testbench;
  import crcps_pkg::*;

  localparam int unsigned EntryBytes    = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainLimit    = 20000;

  typedef enum int unsigned {SinkOpen, SinkCoin, SinkPeriodic, SinkMostly} sink_style_e;
  typedef enum int unsigned {MsgWhole, MsgHeadless, MsgNoise} msg_kind_e;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we = 1'b0;
  logic            cfg_wdata = 1'b0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [39:0]     s_tdata = '0;
  logic            s_tlast = 1'b0;
  logic            s_tuser = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [CrcW-1:0] m_tdata;
  int unsigned     mismatches;
  int unsigned     pending;
  int unsigned     burst_left = 0;
  logic            hold_off_req = 1'b0;

  crc32_reflected_with_palette_stride #(.ENTRY_BYTES(EntryBytes)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  crc32_stream_checker #(.ENTRY_BYTES(EntryBytes)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Output side: random stall styles, plus one long hold-off on request.
  initial begin : sink
    sink_style_e style;
    int unsigned span;
    int unsigned period;
    logic        held_off;
    held_off = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        @(posedge clk_i);
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      style  = sink_style_e'($urandom_range(0, 3));
      span   = $urandom_range(4, 60);
      period = $urandom_range(2, 8);
      for (int unsigned tick = 0; tick < span; tick++) begin
        @(posedge clk_i);
        case (style)
          SinkOpen:     m_tready <= 1'b1;
          SinkCoin:     m_tready <= ($urandom_range(0, 1) == 1);
          SinkPeriodic: m_tready <= (tick % period == 0);
          default:      m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [31:0] seed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seed, b};
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
  endtask

  // Drain, let in-flight bytes settle, then write the mode register.
  task automatic write_mode(input logic mode);
    s_tvalid <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    msg_kind_e   kind;
    logic [31:0] seed;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 8) ? MsgWhole : (pick == 8) ? MsgHeadless : MsgNoise;
      case ($urandom_range(0, 7))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom;
      endcase
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      for (int unsigned i = 0; i < len; i++) begin
        case (kind)
          MsgWhole:
            push_byte(8'($urandom), i == 0, i == len - 1, (i == 0) ? seed : $urandom);
          MsgHeadless:
            push_byte(8'($urandom), 1'b0, i == len - 1, $urandom);
          default:
            push_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      $urandom);
        endcase
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    logic phase_mode[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int unsigned waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset mode: bytes with no opening word, single-byte messages, then a headless last byte.
    push_byte(8'h00, 1'b0, 1'b0, 32'hFFFFFFFF);
    push_byte(8'hFF, 1'b0, 1'b1, 32'h00000000);
    push_byte(8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF);
    push_byte(8'h00, 1'b1, 1'b1, 32'h00000000);
    push_byte(8'hA5, 1'b0, 1'b1, 32'h5A5A5A5A);

    // Palette mode: eleven bytes, ending on an unfolded entry byte.
    write_mode(1'b1);
    for (int unsigned i = 0; i < 11; i++)
      push_byte(8'($urandom), i == 0, i == 10, (i == 0) ? 32'h12345678 : $urandom);

    // Switch the mode in the middle of a message.
    push_byte(8'h3C, 1'b1, 1'b0, 32'hDEADBEEF);
    write_mode(1'b0);
    push_byte(8'hC3, 1'b0, 1'b0, 32'h0);
    push_byte(8'h7E, 1'b0, 1'b1, 32'h0);

    for (int unsigned p = 0; p < 5; p++) begin
      write_mode(phase_mode[p]);
      if (p == 2) hold_off_req = 1'b1;
      run_random_phase(320);
    end
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
